[hdl/ttb_pkg.sv]
package ttb_pkg;

  localparam int UNIT_W = 16;
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int WIDE_W = DIFF_W + 1;
  localparam int THR_W = 31;
  localparam logic signed [UNIT_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [THR_W-1:0] THR_RESET = 31'd10737;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef wide_t [2:0] wvec_t;
  typedef unit_t [2:0] uvec_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
    unit_t norm_x;
    unit_t norm_y;
    unit_t norm_z;
  } in_word_t;

  typedef struct packed {
    unit_t tangent_x;
    unit_t tangent_y;
    unit_t tangent_z;
    unit_t bitan_x;
    unit_t bitan_y;
    unit_t bitan_z;
    logic left_handed;
    logic degenerate;
  } out_word_t;

  // one triangle, raw edges relative to vertex 0
  typedef struct packed {
    diff_t [2:0] e1;
    diff_t [2:0] e2;
    diff_t [1:0] t1;
    diff_t [1:0] t2;
    unit_t [2:0] nrm;
  } job_t;

endpackage

[hdl/ttb_queue.sv]
module ttb_queue #(
  parameter int DEPTH = 2
) (
  input logic clk,
  input logic rst,
  input logic push,
  input ttb_pkg::job_t push_data,
  output logic full,
  input logic pop,
  output ttb_pkg::job_t pop_data,
  output logic empty
);
  import ttb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/ttb_front.sv]
module ttb_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input ttb_pkg::in_word_t in_data,
  output logic push,
  output ttb_pkg::job_t push_data,
  input logic q_full
);
  import ttb_pkg::*;

  logic [1:0] phase;
  coord_t p0 [3];
  coord_t p1 [3];
  coord_t tc0 [2];
  coord_t tc1 [2];
  unit_t nrm [3];
  logic last;
  logic acc;
  coord_t pin [3];
  coord_t tin [2];

  assign last = phase[1];  // phase 3 never occurs; it would behave as the last vertex
  assign in_stall = last && q_full;
  assign acc = in_valid && !in_stall;
  assign push = acc && last;

  assign pin[0] = in_data.pos_x;
  assign pin[1] = in_data.pos_y;
  assign pin[2] = in_data.pos_z;
  assign tin[0] = in_data.tex_u;
  assign tin[1] = in_data.tex_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.e1[i] = DIFF_W'(p1[i]) - DIFF_W'(p0[i]);
      push_data.e2[i] = DIFF_W'(pin[i]) - DIFF_W'(p0[i]);
      push_data.nrm[i] = nrm[i];
    end
    for (int i = 0; i < 2; i++) begin
      push_data.t1[i] = DIFF_W'(tc1[i]) - DIFF_W'(tc0[i]);
      push_data.t2[i] = DIFF_W'(tin[i]) - DIFF_W'(tc0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && phase == 2'd0) begin
      for (int i = 0; i < 3; i++) p0[i] <= pin[i];
      for (int i = 0; i < 2; i++) tc0[i] <= tin[i];
    end
    if (acc && phase == 2'd1) begin
      for (int i = 0; i < 3; i++) p1[i] <= pin[i];
      for (int i = 0; i < 2; i++) tc1[i] <= tin[i];
      nrm[0] <= in_data.norm_x;
      nrm[1] <= in_data.norm_y;
      nrm[2] <= in_data.norm_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (acc) begin
      phase <= last ? 2'd0 : phase + 2'd1;
    end
  end

endmodule

[hdl/ttb_unit.sv]
module ttb_unit (
  input logic clk,
  input logic rst,
  input logic start,
  input ttb_pkg::wvec_t vec,
  output logic done,
  output ttb_pkg::uvec_t u
);
  import ttb_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE, U_NORM, U_SQ, U_ROOT, U_DLOAD, U_DIV, U_DONE
  } ustate_t;

  ustate_t state;
  logic [WIDE_W-1:0] mag [3];
  logic neg [3];
  logic [1:0] idx;
  logic [61:0] sum;
  logic [62:0] x;
  logic [62:0] r;
  logic [62:0] bitv;
  logic [31:0] len;
  logic [31:0] rem;
  logic [14:0] numlo;
  logic [14:0] q;
  logic [3:0] cnt;

  logic [WIDE_W-1:0] m;
  logic [5:0] lead;
  logic [29:0] shifted [3];
  logic [59:0] sq;
  logic [61:0] sum_next;
  logic [62:0] trial;
  logic [44:0] num;
  logic [32:0] rem2;
  logic qbit;
  logic [14:0] q_next;

  assign done = (state == U_DONE);

  always_comb begin
    m = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag[i] > m) m = mag[i];
    end
    lead = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (m[i]) lead = 6'(i);
    end
    // bring the largest magnitude into [2^29, 2^30)
    for (int i = 0; i < 3; i++) begin
      if (lead >= 6'd29) shifted[i] = 30'(mag[i] >> (lead - 6'd29));
      else shifted[i] = 30'(mag[i] << (6'd29 - lead));
    end
    sq = mag[idx][29:0] * mag[idx][29:0];
    sum_next = sum + 62'(sq);
    trial = r + bitv;
    num = {mag[idx][29:0], 14'd0} + 45'(len >> 1);
    rem2 = {rem, numlo[14]};
    qbit = (rem2 >= 33'(len));
    q_next = {q[13:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: if (start) state <= U_NORM;
        U_NORM: state <= (m == '0) ? U_DONE : U_SQ;
        U_SQ: if (idx == 2'd2) state <= U_ROOT;
        U_ROOT: if (bitv[0]) state <= U_DLOAD;
        U_DLOAD: state <= U_DIV;
        U_DIV: if (cnt == 4'd14) state <= (idx == 2'd2) ? U_DONE : U_DLOAD;
        U_DONE: state <= U_IDLE;
        default: state <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vec[i][WIDE_W-1];
          mag[i] <= vec[i][WIDE_W-1] ? WIDE_W'(-$signed(vec[i])) : vec[i];
        end
      end
      U_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= WIDE_W'(shifted[i]);
          u[i] <= '0;
        end
        sum <= '0;
        idx <= 2'd0;
      end
      U_SQ: begin
        sum <= sum_next;
        idx <= idx + 2'd1;
        if (idx == 2'd2) begin
          x <= 63'(sum_next);
          r <= '0;
          bitv <= 63'(1) << 62;
        end
      end
      U_ROOT: begin
        if (x >= trial) begin
          x <= x - trial;
          r <= (r >> 1) + bitv;
          if (bitv[0]) len <= 32'((r >> 1) + bitv);
        end else begin
          r <= r >> 1;
          if (bitv[0]) len <= 32'(r >> 1);
        end
        bitv <= bitv >> 2;
        idx <= 2'd0;
      end
      U_DLOAD: begin
        rem <= 32'(num[44:15]);
        numlo <= num[14:0];
        q <= '0;
        cnt <= '0;
      end
      U_DIV: begin
        rem <= qbit ? 32'(rem2 - 33'(len)) : rem2[31:0];
        numlo <= {numlo[13:0], 1'b0};
        q <= q_next;
        cnt <= cnt + 4'd1;
        if (cnt == 4'd14) begin
          u[idx] <= neg[idx] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
          idx <= idx + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/ttb_back.sv]
module ttb_back (
  input logic clk,
  input logic rst,
  input logic [ttb_pkg::THR_W-1:0] det_threshold,
  input logic q_empty,
  output logic pop,
  input ttb_pkg::job_t job_in,
  output logic out_valid,
  input logic out_stall,
  output ttb_pkg::out_word_t out_data
);
  import ttb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UE1, S_UE2, S_UT1, S_UT2, S_DET, S_CMP, S_TB, S_UT, S_UB,
    S_HAND, S_OUT
  } state_t;

  state_t state;
  job_t job;
  logic launched;
  logic [3:0] step;
  unit_t e1 [3];
  unit_t e2 [3];
  unit_t te1 [2];
  unit_t te2 [2];
  unit_t tn [3];
  unit_t bn [3];
  wide_t tvec [3];
  wide_t bvec [3];
  wide_t cx;
  wide_t cy;
  wide_t cz;
  logic signed [31:0] det;
  logic degen;
  logic hand;
  logic signed [51:0] acc;

  logic is_u;
  logic u_start;
  logic u_done;
  wvec_t u_vec;
  uvec_t u_res;
  logic signed [WIDE_W-1:0] ma;
  logic signed [16:0] mb;
  logic first;
  logic sub;
  logic signed [50:0] prod;
  logic signed [51:0] acc_next;
  logic signed [51:0] tb_val;
  logic [1:0] j;
  logic signed [31:0] adet;
  logic degen_next;
  logic store_ok;

  assign is_u = (state == S_UE1) || (state == S_UE2) || (state == S_UT1) ||
                (state == S_UT2) || (state == S_UT) || (state == S_UB);
  assign u_start = is_u && !launched;
  assign pop = (state == S_IDLE) && !q_empty;
  assign j = step[3:2];
  assign store_ok = !out_valid || !out_stall;

  ttb_unit u_unit (
    .clk(clk),
    .rst(rst),
    .start(u_start),
    .vec(u_vec),
    .done(u_done),
    .u(u_res)
  );

  always_comb begin
    u_vec = '0;
    case (state)
      S_UE1: for (int i = 0; i < 3; i++) u_vec[i] = WIDE_W'(job.e1[i]);
      S_UE2: for (int i = 0; i < 3; i++) u_vec[i] = WIDE_W'(job.e2[i]);
      S_UT1: for (int i = 0; i < 2; i++) u_vec[i] = WIDE_W'(job.t1[i]);
      S_UT2: for (int i = 0; i < 2; i++) u_vec[i] = WIDE_W'(job.t2[i]);
      S_UT: for (int i = 0; i < 3; i++) u_vec[i] = tvec[i];
      S_UB: for (int i = 0; i < 3; i++) u_vec[i] = bvec[i];
      default: u_vec = '0;
    endcase
  end

  // operand selection for the shared multiply-accumulate
  always_comb begin
    ma = '0;
    mb = '0;
    first = 1'b1;
    sub = 1'b0;
    case (state)
      S_DET: begin
        first = (step == 4'd0);
        sub = !first;
        ma = first ? WIDE_W'(te1[0]) : WIDE_W'(te1[1]);
        mb = first ? 17'(te2[1]) : 17'(te2[0]);
      end
      S_TB: begin
        first = !step[0];
        sub = step[0];
        case (step[1:0])
          2'd0: begin ma = WIDE_W'(e1[j]); mb = 17'(te2[1]); end
          2'd1: begin ma = WIDE_W'(e2[j]); mb = 17'(te1[1]); end
          2'd2: begin ma = WIDE_W'(e2[j]); mb = 17'(te1[0]); end
          default: begin ma = WIDE_W'(e1[j]); mb = 17'(te2[0]); end
        endcase
      end
      S_HAND: begin
        first = (step == 4'd0) || (step == 4'd2) || (step == 4'd4) || (step == 4'd6);
        sub = (step == 4'd1) || (step == 4'd3) || (step == 4'd5);
        case (step)
          4'd0: begin ma = WIDE_W'(job.nrm[1]); mb = 17'(tn[2]); end
          4'd1: begin ma = WIDE_W'(job.nrm[2]); mb = 17'(tn[1]); end
          4'd2: begin ma = WIDE_W'(job.nrm[2]); mb = 17'(tn[0]); end
          4'd3: begin ma = WIDE_W'(job.nrm[0]); mb = 17'(tn[2]); end
          4'd4: begin ma = WIDE_W'(job.nrm[0]); mb = 17'(tn[1]); end
          4'd5: begin ma = WIDE_W'(job.nrm[1]); mb = 17'(tn[0]); end
          4'd6: begin ma = cx; mb = 17'(bn[0]); end
          4'd7: begin ma = cy; mb = 17'(bn[1]); end
          default: begin ma = cz; mb = 17'(bn[2]); end
        endcase
      end
      default: begin
      end
    endcase
    prod = ma * mb;
    if (first) acc_next = 52'(prod);
    else if (sub) acc_next = acc - 52'(prod);
    else acc_next = acc + 52'(prod);
    tb_val = det[31] ? -acc_next : acc_next;
    adet = det[31] ? -det : det;
    degen_next = {adet[30:0], 2'b00} < {2'b00, det_threshold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launched <= 1'b0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (state == S_OUT && store_ok) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (u_start) launched <= 1'b1;
      if (u_done) launched <= 1'b0;
      case (state)
        S_IDLE: if (!q_empty) state <= S_UE1;
        S_UE1: if (u_done) state <= S_UE2;
        S_UE2: if (u_done) state <= S_UT1;
        S_UT1: if (u_done) state <= S_UT2;
        S_UT2: if (u_done) begin
          state <= S_DET;
          step <= '0;
        end
        S_DET: begin
          step <= step + 4'd1;
          if (step == 4'd1) state <= S_CMP;
        end
        S_CMP: begin
          step <= '0;
          state <= degen_next ? S_HAND : S_TB;
        end
        S_TB: begin
          step <= step + 4'd1;
          if (step == 4'd11) state <= S_UT;
        end
        S_UT: if (u_done) state <= S_UB;
        S_UB: if (u_done) begin
          state <= S_HAND;
          step <= '0;
        end
        S_HAND: begin
          step <= step + 4'd1;
          if (step == 4'd8) state <= S_OUT;
        end
        S_OUT: if (store_ok) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    case (state)
      S_IDLE: job <= job_in;
      S_UE1: if (u_done) for (int i = 0; i < 3; i++) e1[i] <= u_res[i];
      S_UE2: if (u_done) for (int i = 0; i < 3; i++) e2[i] <= u_res[i];
      S_UT1: if (u_done) for (int i = 0; i < 2; i++) te1[i] <= u_res[i];
      S_UT2: if (u_done) for (int i = 0; i < 2; i++) te2[i] <= u_res[i];
      S_DET: if (step == 4'd1) det <= acc_next[31:0];
      S_CMP: begin
        degen <= degen_next;
        tn[0] <= ONE_Q14;
        tn[1] <= '0;
        tn[2] <= '0;
        bn[0] <= '0;
        bn[1] <= ONE_Q14;
        bn[2] <= '0;
      end
      S_TB: begin
        if (step[1:0] == 2'd1) tvec[j] <= tb_val[WIDE_W-1:0];
        if (step[1:0] == 2'd3) bvec[j] <= tb_val[WIDE_W-1:0];
      end
      S_UT: if (u_done) for (int i = 0; i < 3; i++) tn[i] <= u_res[i];
      S_UB: if (u_done) for (int i = 0; i < 3; i++) bn[i] <= u_res[i];
      S_HAND: begin
        if (step == 4'd1) cx <= acc_next[WIDE_W-1:0];
        if (step == 4'd3) cy <= acc_next[WIDE_W-1:0];
        if (step == 4'd5) cz <= acc_next[WIDE_W-1:0];
        if (step == 4'd8) hand <= acc_next[51];
      end
      S_OUT: if (store_ok) begin
        out_data.tangent_x <= tn[0];
        out_data.tangent_y <= tn[1];
        out_data.tangent_z <= tn[2];
        out_data.bitan_x <= bn[0];
        out_data.bitan_y <= bn[1];
        out_data.bitan_z <= bn[2];
        out_data.left_handed <= hand;
        out_data.degenerate <= degen;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/triangle_tangent_basis.sv]
// Triangle tangent-space basis. Vertices arrive one word at a time on the in
// channel; every third vertex closes a triangle and produces one result word
// (tangent, bitangent in Q2.14, handedness, degenerate flag). Only the closing
// vertex can stall; it is pushed as a job into a small queue to wait while
// the back end is busy. The back end runs the shared normalize unit up to
// six times per job (four with the fallback basis): a 32-step square root,
// then a divide per component; a zero vector skips both. det_threshold is
// written through cfg_we/cfg_data; the user must write it only while the
// block is idle, since the block itself does not enforce this.
module triangle_tangent_basis #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [ttb_pkg::THR_W-1:0] cfg_data,
  input logic in_valid,
  output logic in_stall,
  input ttb_pkg::in_word_t in_data,
  output logic out_valid,
  input logic out_stall,
  output ttb_pkg::out_word_t out_data
);
  import ttb_pkg::*;

  logic [THR_W-1:0] det_threshold;
  logic push;
  job_t push_data;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t pop_data;

  // degenerate limit on |det|, units of 2^-30
  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_RESET;
    end else if (cfg_we) begin
      det_threshold <= cfg_data;
    end
  end

  // front: groups vertices, forms raw edges
  ttb_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .push(push),
    .push_data(push_data),
    .q_full(q_full)
  );

  // triangle jobs wait here while the back end is busy
  ttb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(q_full),
    .pop(pop),
    .pop_data(pop_data),
    .empty(q_empty)
  );

  // back: normalize, solve, handedness, output register
  ttb_back u_back (
    .clk(clk),
    .rst(rst),
    .det_threshold(det_threshold),
    .q_empty(q_empty),
    .pop(pop),
    .job_in(pop_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
